// ===== rtl/itra_pkg.sv =====
// ----------------------------------------------------------------------------
// itra_pkg
// Shared constants and helpers for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;
    localparam int BIT_W          = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd65;  // 'A'
    localparam logic [RADIX_W-1:0] DEC_TEN   = 6'd10;

    // Clamp the programmed base into 2..36.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    // Highest quotient bit a digit of base b can need (digit <= b-1).
    function automatic logic [BIT_W-1:0] top_bit(input logic [RADIX_W-1:0] b);
        if (b <= 6'd2) begin
            return 3'd0;
        end else if (b <= 6'd4) begin
            return 3'd1;
        end else if (b <= 6'd8) begin
            return 3'd2;
        end else if (b <= 6'd16) begin
            return 3'd3;
        end else if (b <= 6'd32) begin
            return 3'd4;
        end
        return 3'd5;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        if (d < DEC_TEN) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_ALPHA + CHAR_W'(d - DEC_TEN);
    endfunction

endpackage

// ===== rtl/itra_ram.sv =====
// ----------------------------------------------------------------------------
// itra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// Sequence: climb powers of the base, storing each, then per digit shift-subtract
//   its quotient bits (1 for base 2, up to 6 for bases 33..36) and emit it, holding
//   the digit until it is taken; every digit after the first needs one power fetch.
// A new value is accepted only once the last digit of the previous one is taken.
// Reset: aresetn synchronous active low; radix returns to 10, sequencer to idle.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a non-negative integer to its ASCII digits in base 2..36, MSB first.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [RADIX_W-1:0]    cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_digit_char,
    output logic                  m_last_digit
);

    // Wide enough for a power times the base, or a power shifted by up to five.
    localparam int PW = VALUE_BITS + RADIX_W;
    localparam int AW = $clog2(VALUE_BITS);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a value
    localparam logic [2:0] ST_POW   = 3'd1;  // climb powers of the base, store each
    localparam logic [2:0] ST_DIV   = 3'd2;  // shift-subtract one quotient bit a cycle
    localparam logic [2:0] ST_EMIT  = 3'd3;  // digit held on the result port
    localparam logic [2:0] ST_FETCH = 3'd4;  // next lower power arrives from RAM

    logic [2:0]            state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;      // value still to be digitized
    logic [VALUE_BITS-1:0] pow_reg, pow_next;      // current power of the base
    logic [AW-1:0]         cnt_reg, cnt_next;      // exponent of pow_reg
    logic [BIT_W-1:0]      bit_reg, bit_next;      // quotient bit under test
    logic [RADIX_W-1:0]    dig_reg, dig_next;      // digit being built

    logic [PW-1:0]         prod;
    logic [PW-1:0]         trial;
    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Datapath: one narrow multiply for the power climb, one shift+compare
    // +subtract for digit extraction.
    assign prod  = PW'(pow_reg) * PW'(base_reg);
    assign trial = PW'(pow_reg) << bit_reg;

    // Power stack: each power written during the climb, read back on the way down.
    assign ram_we = (state_reg == ST_POW);

    itra_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (VALUE_BITS)
    ) u_pow_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (pow_reg),
        .raddr (AW'(cnt_reg - AW'(1))),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_EMIT);
    assign m_digit_char = digit_ascii(dig_reg);
    assign m_last_digit = (cnt_reg == '0);

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        rem_next   = rem_reg;
        pow_next   = pow_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next  = eff_radix(radix_reg);
                    rem_next   = s_value;
                    pow_next   = VALUE_BITS'(1);
                    cnt_next   = '0;
                    state_next = ST_POW;
                end
            end
            ST_POW: begin
                if (prod <= PW'(rem_reg)) begin
                    pow_next = prod[VALUE_BITS-1:0];
                    cnt_next = AW'(cnt_reg + AW'(1));
                end else begin
                    bit_next   = top_bit(base_reg);
                    dig_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial <= PW'(rem_reg)) begin
                    rem_next = rem_reg - trial[VALUE_BITS-1:0];
                    dig_next = dig_reg | (RADIX_W'(1) << bit_reg);
                end
                if (bit_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        // RAM read of cnt-1 was launched this cycle
                        cnt_next   = AW'(cnt_reg - AW'(1));
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                pow_next   = ram_rdata;
                bit_next   = top_bit(base_reg);
                dig_next   = '0;
                state_next = ST_DIV;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        rem_reg  <= rem_next;
        pow_reg  <= pow_next;
        cnt_reg  <= cnt_next;
        bit_reg  <= bit_next;
        dig_reg  <= dig_next;
    end

endmodule

// ===== rtl/itra_chk.sv =====
// ----------------------------------------------------------------------------
// itra_chk
// Port-level checks for the radix ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
module itra_chk
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [VALUE_BITS-1:0] s_value,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [CHAR_W-1:0]     m_digit_char,
    input logic                  m_last_digit
);

    // Stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char) && $stable(m_last_digit))
        else $error("result changed while stalled");

    // One item at a time: never ready while a digit is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after input transfer");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= 7'd48 && m_digit_char <= 7'd57) ||
                    (m_digit_char >= 7'd65 && m_digit_char <= 7'd90))
        else $error("digit char out of range");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_digit |=> s_ready)
        else $error("not idle after last digit");

endmodule

bind integer_to_radix_ascii itra_chk #(.VALUE_BITS(VALUE_BITS)) u_itra_chk (.*);

// ===== test/radix_digit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_checker
// Watches the radix writes and both channels of the converter. It builds the
// digit string for every value transfer and compares each digit transfer,
// in order, against it.
// ----------------------------------------------------------------------------
module radix_digit_checker
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [RADIX_W-1:0]    cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CHAR_W-1:0]     m_digit_char,
    input  logic                  m_last_digit,
    output int                    mismatches,
    output int                    digits_left,
    output int                    digits_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    digit_t             expected_digits[$];
    digit_t             want;
    logic [RADIX_W-1:0] radix_q;

    initial begin
        mismatches     = 0;
        digits_left    = 0;
        digits_checked = 0;
        radix_q        = RADIX_RESET;
    end

    // Expand one value into its digits, most significant first.
    function automatic void queue_digits(input logic [VALUE_BITS-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0]    base;
        logic [VALUE_BITS-1:0] rest;
        logic [RADIX_W-1:0]    d;
        logic [CHAR_W-1:0]     msd_first[$];
        base = radix;
        if (radix < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        rest = value;
        // zero still yields one '0'
        do begin
            d = RADIX_W'(rest % base);
            msd_first.push_front(d < DEC_TEN ? CHAR_ZERO + CHAR_W'(d)
                                             : CHAR_ALPHA + CHAR_W'(d - DEC_TEN));
            rest = rest / base;
        end while (rest != 0);
        foreach (msd_first[i]) begin
            expected_digits.push_back('{ch: msd_first[i],
                                        last: (i == msd_first.size() - 1)});
        end
    endfunction

    task automatic flag_digit(input string wanted);
        if (mismatches < 10) begin
            $display("%0t: digit transfer wrong: expected %s, got char 0x%0h last %0b",
                     $realtime, wanted, m_digit_char, m_last_digit);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            radix_q = RADIX_RESET;
        end else begin
            if (s_valid && s_ready) begin
                queue_digits(s_value, radix_q);
            end
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    flag_digit("nothing");
                end else begin
                    want = expected_digits.pop_front();
                    if (want.ch !== m_digit_char || want.last !== m_last_digit) begin
                        flag_digit($sformatf("char 0x%0h last %0b", want.ch, want.last));
                    end
                    digits_checked++;
                end
            end
            if (cfg_we) begin
                radix_q = cfg_wdata;
            end
        end
        digits_left = expected_digits.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Radix ASCII converter test: directed corner values under the reset base,
// bases 2, 36 and 16 and out-of-range base codes, then random values over
// random bases, with idle bursts on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import itra_pkg::*;

    localparam int VW            = VALUE_BITS_DEF;
    localparam int RANDOM_PHASES = 10;
    localparam int PER_PHASE     = 15;
    localparam int LONG_HOLD     = 300;  // output stall that backs up the input
    localparam int SETTLE        = 4;    // idle cycles before a radix write
    localparam int TAIL          = 140;  // above the worst conversion latency

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [RADIX_W-1:0]  cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [VW-1:0]       s_value   = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [CHAR_W-1:0]   m_digit_char;
    logic                m_last_digit;

    // traffic shaping, shared between the sender and receiver processes
    logic sender_gaps     = 1'b0;
    logic receiver_stalls = 1'b0;
    int   hold_left       = 0;
    int   stall_left      = 0;

    int items_sent   = 0;
    int radix_writes = 0;
    int mismatches;
    int digits_left;
    int digits_checked;

    integer_to_radix_ascii #(.VALUE_BITS(VW)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    radix_digit_checker #(.VALUE_BITS(VW)) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_char   (m_digit_char),
        .m_last_digit   (m_last_digit),
        .mismatches     (mismatches),
        .digits_left    (digits_left),
        .digits_checked (digits_checked)
    );

    // 4 ns clock, starts low so the first rising edge sees reset asserted
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Receiver: a long hold when one is requested, else random stall bursts
    // while stalls are enabled, else always ready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (receiver_stalls && stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Random value: full range, tiny values, random magnitude, or all ones
    // of random length (longest digit strings in power-of-two bases).
    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = VW'($urandom);
            end
            1: begin
                v = VW'($urandom_range(0, 40));
            end
            2: begin
                v = VW'($urandom) >> $urandom_range(1, VW - 1);
            end
            default: begin
                v = {VW{1'b1}} >> $urandom_range(0, VW - 1);
            end
        endcase
        return v;
    endfunction

    // One value transfer. Called at a falling edge, returns at a falling edge.
    // A gap drops valid first, so valid is never lowered and raised in one step.
    task automatic send_value(input logic [VW-1:0] v);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_value <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Sender pauses until every predicted digit has been transferred.
    task automatic wait_for_digits();
        s_valid <= 1'b0;
        while (digits_left != 0) begin
            @(negedge aclk);
        end
    endtask

    // Radix writes only happen with the converter idle.
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        wait_for_digits();
        repeat (SETTLE) @(negedge aclk);
        cfg_wdata <= r;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        radix_writes++;
    endtask

    initial begin
        logic [RADIX_W-1:0] r;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        // reset base 10: zero, digit edges, full-scale value
        send_value('0);
        send_value(VW'(9));
        send_value(VW'(10));
        send_value(VW'(99));
        send_value({VW{1'b1}});

        // base 2: longest strings
        set_radix(RADIX_MIN);
        send_value('0);
        send_value(VW'(1));
        send_value(VW'(1) << (VW - 1));
        send_value({VW{1'b1}});

        // base 36: 'Z', first and last two-digit values, full scale
        set_radix(RADIX_MAX);
        send_value(VW'(35));
        send_value(VW'(36));
        send_value(VW'(1295));
        send_value({VW{1'b1}});

        // base codes below two act as base 2
        set_radix('0);
        send_value(VW'(6));
        set_radix(RADIX_W'(1));
        send_value(VW'(7));

        // base codes above 36 act as base 36
        set_radix(RADIX_W'(37));
        send_value(VW'(35));
        set_radix({RADIX_W{1'b1}});
        send_value(VW'(1296));

        // base 16: hex letters
        set_radix(RADIX_W'(16));
        send_value(VW'(255));
        send_value(VW'(3));

        // Random part: a fresh base per phase. Phase 2 holds the output long
        // enough to back up the input; phase 4 and the last two run without
        // any idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sender_gaps     = (p < RANDOM_PHASES - 2) && (p != 4);
            receiver_stalls = sender_gaps;
            case (p)
                0: begin
                    r = RADIX_MIN;
                end
                1: begin
                    r = RADIX_MAX;
                end
                default: begin
                    r = RADIX_W'($urandom_range(0, 63));
                end
            endcase
            set_radix(r);
            if (p == 2) begin
                hold_left = LONG_HOLD;
            end
            repeat (PER_PHASE) send_value(pick_value());
        end

        wait_for_digits();
        repeat (TAIL) @(negedge aclk);

        $display("Converted %0d values across %0d radix writes and the reset base;",
                 items_sent, radix_writes);
        $display("%0d digit transfers compared, including out-of-range base codes.",
                 digits_checked);
        if (mismatches == 0 && digits_left == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
